// File: design/arm_pkg.sv
// ----------------------------------------------------------------------------
// Address region map package
// Shared request codes, handler codes and the queue word between the front
// and back ends.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int AddrWidth = 16;
  localparam int DevWidth  = 4;
  localparam int DataWidth = 8;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_READ  = 3'd1,
    REQ_GET   = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_PLACE = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    HND_NONE  = 3'd0,
    HND_READ  = 3'd1,
    HND_GET   = 3'd2,
    HND_WRITE = 3'd3,
    HND_PLACE = 3'd4
  } hnd_t;

  localparam logic [1:0] CFG_READ  = 2'd0;
  localparam logic [1:0] CFG_GET   = 2'd1;
  localparam logic [1:0] CFG_WRITE = 2'd2;
  localparam logic [1:0] CFG_PLACE = 2'd3;

  localparam logic [AddrWidth-1:0] ADDR_MAX = 16'hFFFF;
  localparam logic [AddrWidth-1:0] ADDR_MIN = 16'h0000;

  // Classified word handed from front to back
  typedef struct packed {
    logic                 is_add;
    logic                 is_access;
    logic [2:0]           req;
    logic [AddrWidth-1:0] lo;
    logic [AddrWidth-1:0] hi;
    logic [DevWidth-1:0]  dev;
    logic [DataWidth-1:0] data;
  } word_t;

endpackage

// File: design/address_region_map_top.sv
// ----------------------------------------------------------------------------
// Address region map
// Sorted region table decoder with per-device handler selection.
//
//  channel   handshake            payload
//  request   start / busy         req_type address range_end device_id write_data
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//  result    done strobe          handler target_device relative_address
//                                 data_out status
//
// An access passes through the two-word queue and a registered result
// before done rises; the back end decodes one access a cycle while no add is
// in progress. An add walks the table piece by piece, answers, then copies
// the scratch table back, one entry a cycle, unless the new table overflows.
// Reset leaves one region covering the whole space, owned by device 0.
// Results cannot be stalled; busy rises when the two-word queue is full.
// ----------------------------------------------------------------------------
module address_region_map_top #(
  parameter int MAX_REGIONS  = 32,
  parameter int DEVICE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [15:0] address,
  input  logic [15:0] range_end,
  input  logic [3:0]  device_id,
  input  logic [7:0]  write_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [2:0]  handler,
  output logic [3:0]  target_device,
  output logic [15:0] relative_address,
  output logic [7:0]  data_out,
  output logic [0:0]  status
);
  import arm_pkg::*;

  logic [15:0] read_mask, get_mask, write_mask, place_mask;
  logic        q_valid, q_pop;
  word_t       q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_mask  <= '0;
      get_mask   <= '0;
      write_mask <= '0;
      place_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_READ:  read_mask  <= cfg_data;
        CFG_GET:   get_mask   <= cfg_data;
        CFG_WRITE: write_mask <= cfg_data;
        CFG_PLACE: place_mask <= cfg_data;
        default:   read_mask  <= read_mask;
      endcase
    end
  end

  arm_front u_front (
    .clk, .rst,
    .in_valid (start),
    .in_req   (req_type),
    .in_addr  (address),
    .in_end   (range_end),
    .in_dev   (device_id),
    .in_data  (write_data),
    .full     (busy),
    .q_valid, .q_word, .q_pop
  );

  arm_back #(.MAX_REGIONS(MAX_REGIONS), .DEVICE_COUNT(DEVICE_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_word, .q_pop,
    .read_mask, .get_mask, .write_mask, .place_mask,
    .res_valid   (done),
    .res_handler (handler),
    .res_device  (target_device),
    .res_rel     (relative_address),
    .res_data    (data_out),
    .res_status  (status[0])
  );
endmodule

// File: design/arm_front.sv
// ----------------------------------------------------------------------------
// Address region map front end
// Accepts request words, swaps reversed bounds and queues them.
// ----------------------------------------------------------------------------
module arm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [2:0]                   in_req,
  input  logic [arm_pkg::AddrWidth-1:0] in_addr,
  input  logic [arm_pkg::AddrWidth-1:0] in_end,
  input  logic [arm_pkg::DevWidth-1:0]  in_dev,
  input  logic [arm_pkg::DataWidth-1:0] in_data,
  output logic                         full,
  output logic                         q_valid,
  output arm_pkg::word_t               q_word,
  input  logic                         q_pop
);
  import arm_pkg::*;

  word_t      fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  word_t      w;
  logic       push;
  logic       swap;

  // Swap bounds of an add only; an access keeps its address as given
  assign swap = (in_req == REQ_ADD) && (in_addr > in_end);

  always_comb begin
    w.req       = in_req;
    w.is_add    = (in_req == REQ_ADD);
    w.is_access = (in_req == REQ_READ) || (in_req == REQ_GET) ||
                  (in_req == REQ_WRITE) || (in_req == REQ_PLACE);
    w.lo        = swap ? in_end : in_addr;
    w.hi        = swap ? in_addr : in_end;
    w.dev       = in_dev;
    w.data      = in_data;
  end

  assign push    = in_valid && !full;
  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_word  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
      (push && !q_pop && count == 2'd0) |=> count == 2'd1)
    else $error("queue count did not advance");
endmodule

// File: design/arm_back.sv
// ----------------------------------------------------------------------------
// Address region map back end
// Decodes accesses combinationally into a registered result; rebuilds the
// region table for adds by walking it piece by piece into a scratch table, then copying back unless it overflows.
// ----------------------------------------------------------------------------
module arm_back #(
  parameter int MAX_REGIONS  = 32,
  parameter int DEVICE_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  arm_pkg::word_t                q_word,
  output logic                          q_pop,
  input  logic [15:0]                   read_mask,
  input  logic [15:0]                   get_mask,
  input  logic [15:0]                   write_mask,
  input  logic [15:0]                   place_mask,
  output logic                          res_valid,
  output logic [2:0]                    res_handler,
  output logic [arm_pkg::DevWidth-1:0]  res_device,
  output logic [arm_pkg::AddrWidth-1:0] res_rel,
  output logic [arm_pkg::DataWidth-1:0] res_data,
  output logic                          res_status
);
  import arm_pkg::*;

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 3);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_PUSH = 4'b0100,
    S_COPY = 4'b1000
  } state_t;

  state_t state;

  logic [AddrWidth-1:0] r_start [MAX_REGIONS];
  logic [AddrWidth-1:0] r_last  [MAX_REGIONS];
  logic [AddrWidth-1:0] r_base  [MAX_REGIONS];
  logic [DevWidth-1:0]  r_owner [MAX_REGIONS];
  logic [CW-1:0]        count;

  logic [AddrWidth-1:0] n_start [MAX_REGIONS];
  logic [AddrWidth-1:0] n_last  [MAX_REGIONS];
  logic [AddrWidth-1:0] n_base  [MAX_REGIONS];
  logic [DevWidth-1:0]  n_owner [MAX_REGIONS];
  logic [CW-1:0]        ncount;
  logic [DevWidth-1:0]  prev_owner;

  word_t                cur;
  logic [CW-1:0]        idx;
  logic [1:0]           phase;
  logic [AddrWidth-1:0] p_first [3];
  logic [AddrWidth-1:0] p_last  [3];
  logic [AddrWidth-1:0] p_base  [3];
  logic [DevWidth-1:0]  p_owner [3];
  logic [2:0]           p_en;

  logic                 hit_any;
  logic [IW-1:0]        hit_idx;
  logic [DevWidth-1:0]  tgt;
  logic [AddrWidth-1:0] rel;
  logic [2:0]           hnd;

  function automatic logic cap(input logic [15:0] m, input logic [DevWidth-1:0] d);
    logic ok;
    ok = (d != '0) && (32'(d) < DEVICE_COUNT) && m[d];
    return ok;
  endfunction

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if ((CW'(i) < count) && q_word.lo >= r_start[i] && q_word.lo <= r_last[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
    end
    tgt = hit_any ? r_owner[hit_idx] : '0;
    rel = hit_any ? r_base[hit_idx] + (q_word.lo - r_start[hit_idx]) : '0;
    hnd = HND_NONE;
    priority case (q_word.req)
      REQ_READ:  if (cap(read_mask, tgt)) hnd = HND_READ;
      REQ_GET:   if (cap(get_mask, tgt)) hnd = HND_GET;
                 else if (cap(read_mask, tgt)) hnd = HND_READ;
      REQ_WRITE: if (cap(write_mask, tgt)) hnd = HND_WRITE;
      REQ_PLACE: if (cap(place_mask, tgt)) hnd = HND_PLACE;
                 else if (cap(write_mask, tgt)) hnd = HND_WRITE;
      default:   hnd = HND_NONE;
    endcase
  end

  // Up to three pieces per walked entry: lower remnant, new region, upper remnant
  logic [IW-1:0]        wi;
  logic                 overlap;
  always_comb begin
    wi = idx[IW-1:0];
    overlap = !(cur.hi < r_start[wi] || cur.lo > r_last[wi]);
    p_en       = 3'b000;
    p_first[0] = r_start[wi];
    p_last[0]  = overlap ? cur.lo - 16'd1 : r_last[wi];
    p_base[0]  = r_base[wi];
    p_owner[0] = r_owner[wi];
    p_first[1] = cur.lo;
    p_last[1]  = cur.hi;
    p_base[1]  = '0;
    p_owner[1] = cur.dev;
    p_first[2] = cur.hi + 16'd1;
    p_last[2]  = r_last[wi];
    p_base[2]  = r_base[wi] + (cur.hi + 16'd1 - r_start[wi]);
    p_owner[2] = r_owner[wi];
    if (!overlap) p_en = 3'b001;
    else begin
      p_en[0] = cur.lo > r_start[wi];
      p_en[1] = 1'b1;
      p_en[2] = cur.hi < r_last[wi];
    end
  end

  logic [1:0]    pi;
  logic          do_push;
  logic          merge;
  logic [IW-1:0] ni;
  logic          last_piece;
  always_comb begin
    pi = phase;
    do_push = (state == S_PUSH) && p_en[pi];
    merge = (ncount != '0) && (prev_owner == p_owner[pi]);
    ni = ncount[IW-1:0];
    last_piece = (pi == 2'd2) || (pi == 2'd1 && !p_en[2]) ||
                 (pi == 2'd0 && !p_en[1] && !p_en[2]);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (do_push && merge && ncount != '0) n_last[ni - IW'(1)] <= p_last[pi];
    else if (do_push && !merge && 32'(ncount) < MAX_REGIONS) begin
      n_start[ni] <= p_first[pi];
      n_last[ni]  <= p_last[pi];
      n_base[ni]  <= p_base[pi];
      n_owner[ni] <= p_owner[pi];
    end
    if (q_pop) cur <= q_word;
    if (rst) begin
      r_start[0] <= ADDR_MIN;
      r_last[0]  <= ADDR_MAX;
      r_base[0]  <= '0;
      r_owner[0] <= '0;
    end else if (state == S_COPY && ncount <= CW'(MAX_REGIONS) && idx < ncount) begin
      r_start[wi] <= n_start[wi];
      r_last[wi]  <= n_last[wi];
      r_base[wi]  <= n_base[wi];
      r_owner[wi] <= n_owner[wi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= CW'(1);
      ncount     <= '0;
      idx        <= '0;
      phase      <= '0;
      prev_owner <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_word.is_add) begin
              state  <= S_PUSH;
              idx    <= '0;
              phase  <= '0;
              ncount <= '0;
            end else begin
              res_valid   <= 1'b1;
              res_handler <= q_word.is_access ? hnd : HND_NONE;
              res_device  <= q_word.is_access ? tgt : '0;
              res_rel     <= q_word.is_access ? rel : '0;
              res_data    <= (q_word.req == REQ_WRITE || q_word.req == REQ_PLACE) ?
                             q_word.data : '0;
              res_status  <= 1'b0;
            end
          end
        end
        S_PUSH: begin
          if (do_push) begin
            prev_owner <= p_owner[pi];
            if (!merge && ncount <= CW'(MAX_REGIONS)) ncount <= ncount + CW'(1);
          end
          if (!p_en[pi] || last_piece) begin
            phase <= '0;
            if (last_piece || pi == 2'd2) begin
              if (idx + CW'(1) >= count) begin
                state <= S_WALK;
              end
              idx <= idx + CW'(1);
            end else phase <= pi + 2'd1;
          end else phase <= pi + 2'd1;
        end
        S_WALK: begin
          idx <= '0;
          res_valid   <= 1'b1;
          res_handler <= HND_NONE;
          res_device  <= '0;
          res_rel     <= '0;
          res_data    <= '0;
          res_status  <= (ncount > CW'(MAX_REGIONS));
          state <= (ncount > CW'(MAX_REGIONS)) ? S_IDLE : S_COPY;
        end
        S_COPY: begin
          idx <= idx + CW'(1);
          if (idx + CW'(1) >= ncount) begin
            count <= ncount;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst) count != '0)
    else $error("region count dropped to zero");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
      (state == S_WALK) |=> res_valid)
    else $error("add finished without result");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
      (state != S_IDLE) |-> !q_pop)
    else $error("pop while table update active");
endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Address region map testbench
// Drives region adds and accesses through the start/busy port, predicts each
// result from a private copy of the region table and capability masks, and
// compares every done word field by field in order. Masks are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import arm_pkg::*;

  localparam int NREG = 32;
  localparam int NDEV = 16;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] addr;
    logic [15:0] rend;
    logic [3:0]  dev;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [2:0]  hnd;
    logic [3:0]  tgt;
    logic [15:0] rel;
    logic [7:0]  dout;
    logic        stat;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] req_type = '0;
  logic [15:0] address = '0, range_end = '0;
  logic [3:0] device_id = '0;
  logic [7:0] write_data = '0;
  logic cfg_valid = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic busy, cfg_ready, done;
  logic [2:0] handler;
  logic [3:0] target_device;
  logic [15:0] relative_address;
  logic [7:0] data_out;
  logic [0:0] status;

  address_region_map_top u_top (.*);

  initial forever #10 clk = ~clk;

  logic [15:0] map_first[NREG], map_last[NREG], map_base[NREG];
  logic [3:0]  map_owner[NREG];
  int          map_count;
  logic [15:0] mask_rd, mask_get, mask_wr, mask_place;

  item_t   pending[$];
  answer_t expected_answers[$];
  int      mismatches = 0, answers_seen = 0, adds_rejected = 0, cycles = 0;
  int      burst_left = 0, gap_left = 0;
  bit      in_taken = 1'b0;

  function automatic bit allowed(logic [15:0] m, logic [3:0] d);
    return d != 0 && d < NDEV && m[d];
  endfunction

  function automatic logic rebuild_map(logic [15:0] a, logic [15:0] b, logic [3:0] own);
    logic [15:0] f[NREG+2], l[NREG+2], bs[NREG+2];
    logic [3:0]  o[NREG+2];
    logic [15:0] lo, hi;
    int n = 0;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    for (int i = 0; i < map_count; i++) begin
      logic [15:0] pf[3], pl[3], pb[3];
      logic [3:0]  po[3];
      int k = 0;
      if (hi < map_first[i] || lo > map_last[i]) begin
        pf[0] = map_first[i]; pl[0] = map_last[i]; pb[0] = map_base[i];
        po[0] = map_owner[i]; k = 1;
      end else begin
        if (lo > map_first[i]) begin
          pf[k] = map_first[i]; pl[k] = lo - 16'd1; pb[k] = map_base[i];
          po[k] = map_owner[i]; k++;
        end
        pf[k] = lo; pl[k] = hi; pb[k] = '0; po[k] = own; k++;
        if (hi < map_last[i]) begin
          pf[k] = hi + 16'd1; pl[k] = map_last[i];
          pb[k] = map_base[i] + (hi + 16'd1 - map_first[i]);
          po[k] = map_owner[i]; k++;
        end
      end
      for (int j = 0; j < k; j++) begin
        if (n > 0 && o[n-1] == po[j]) l[n-1] = pl[j];
        else if (n < NREG + 2) begin
          f[n] = pf[j]; l[n] = pl[j]; bs[n] = pb[j]; o[n] = po[j]; n++;
        end
      end
    end
    if (n > NREG) return 1'b1;
    for (int i = 0; i < n; i++) begin
      map_first[i] = f[i]; map_last[i] = l[i]; map_base[i] = bs[i]; map_owner[i] = o[i];
    end
    map_count = n;
    return 1'b0;
  endfunction

  function automatic answer_t decode_request(item_t it);
    answer_t r = '0;
    if (it.req == REQ_ADD) begin
      r.stat = rebuild_map(it.addr, it.rend, it.dev);
    end else if (it.req <= REQ_PLACE) begin
      for (int i = 0; i < map_count; i++)
        if (it.addr >= map_first[i] && it.addr <= map_last[i]) begin
          r.tgt = map_owner[i];
          r.rel = map_base[i] + (it.addr - map_first[i]);
          break;
        end
      case (it.req)
        REQ_READ: if (allowed(mask_rd, r.tgt)) r.hnd = HND_READ;
        REQ_GET: begin
          if (allowed(mask_get, r.tgt)) r.hnd = HND_GET;
          else if (allowed(mask_rd, r.tgt)) r.hnd = HND_READ;
        end
        REQ_WRITE: begin
          if (allowed(mask_wr, r.tgt)) r.hnd = HND_WRITE;
          r.dout = it.data;
        end
        default: begin
          if (allowed(mask_place, r.tgt)) r.hnd = HND_PLACE;
          else if (allowed(mask_wr, r.tgt)) r.hnd = HND_WRITE;
          r.dout = it.data;
        end
      endcase
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !in_taken) begin
      start <= 1'b1;
    end else begin
      if (gap_left > 0) gap_left--;
      if (pending.size() > 0 && gap_left == 0) begin
        item_t it;
        it = pending.pop_front();
        start <= 1'b1;
        req_type <= it.req; address <= it.addr; range_end <= it.rend;
        device_id <= it.dev; write_data <= it.data;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    in_taken = !rst && start && !busy;
    if (in_taken)
      expected_answers.push_back(decode_request(
          '{req_type, address, range_end, device_id, write_data}));
    if (!rst && done) begin
      answer_t want;
      answer_t got;
      got = '{handler, target_device, relative_address, data_out, status};
      answers_seen++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got.stat && want.stat) adds_rejected++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp hnd %0d dev %0d rel %h dout %h st %0d, ",
                      "got hnd %0d dev %0d rel %h dout %h st %0d"},
                     want.hnd, want.tgt, want.rel, want.dout, want.stat,
                     got.hnd, got.tgt, got.rel, got.dout, got.stat);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("[address_region_map_top] ERROR");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] rq, logic [15:0] a, logic [15:0] e,
                            logic [3:0] d, logic [7:0] w);
    pending.push_back('{rq, a, e, d, w});
  endtask

  task automatic write_mask(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_READ:  mask_rd = v;
      CFG_GET:   mask_get = v;
      CFG_WRITE: mask_wr = v;
      default:   mask_place = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_access;
    logic [2:0] rq;
    int which;
    rq = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 19) == 0) rq = 3'($urandom_range(5, 7));
    which = $urandom_range(0, map_count - 1);
    queue_item(rq, ($urandom_range(0, 2) == 0) ? 16'($urandom) :
               16'($urandom_range(map_first[which], map_last[which])),
               16'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic random_add;
    logic [15:0] a;
    a = 16'($urandom);
    queue_item(REQ_ADD, a,
               ($urandom_range(0, 1) == 0) ? a + 16'($urandom_range(0, 2000)) :
               16'($urandom), 4'($urandom), 8'($urandom));
  endtask

  initial begin
    map_first[0] = ADDR_MIN; map_last[0] = ADDR_MAX; map_base[0] = '0; map_owner[0] = '0;
    map_count = 1;
    mask_rd = '0; mask_get = '0; mask_wr = '0; mask_place = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed
    queue_item(REQ_READ, ADDR_MIN, '0, '0, '0);
    queue_item(REQ_WRITE, ADDR_MAX, '0, '0, 8'hFF);
    queue_item(REQ_ADD, 16'h2000, 16'h1000, 4'd3, '0);
    queue_item(REQ_ADD, 16'h1800, 16'h27FF, 4'd5, '0);
    queue_item(REQ_ADD, ADDR_MAX, ADDR_MAX, 4'hF, '0);
    queue_item(REQ_ADD, ADDR_MIN, ADDR_MIN, 4'd1, '0);
    queue_item(REQ_ADD, 16'h2800, 16'h2FFF, 4'd5, '0);
    queue_item(REQ_ADD, 16'h8000, 16'h80FF, 4'd0, '0);
    queue_item(REQ_GET, 16'h1234, '0, '0, 8'h55);
    queue_item(REQ_PLACE, 16'h2100, '0, '0, 8'hAA);
    queue_item(REQ_READ, ADDR_MAX, '0, '0, '0);
    queue_item(3'd5, 16'hFFFF, 16'hFFFF, 4'hF, 8'hFF);
    queue_item(3'd7, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: for (int k = 0; k < 4; k++) write_mask(k[1:0], 16'hFFFF);
        1: for (int k = 0; k < 4; k++) write_mask(k[1:0], 16'h0000);
        2: begin
          write_mask(CFG_READ, 16'hFFFF); write_mask(CFG_WRITE, 16'hFFFF);
        end
        default: for (int k = 0; k < 4; k++) write_mask(k[1:0], 16'($urandom));
      endcase
      if (ph == 0)
        for (int k = 0; k < 40; k++)
          queue_item(REQ_ADD, 16'(k * 1500 + 7), 16'(k * 1500 + 700), 4'(k % 15 + 1), '0);
      for (int k = 0; k < 8; k++) begin
        queue_item(REQ_GET, 16'($urandom), '0, '0, '0);
        queue_item(REQ_PLACE, 16'($urandom), '0, '0, 8'($urandom));
      end
      for (int k = 0; k < 110; k++) begin
        while (pending.size() > 4) @(posedge clk);
        if ($urandom_range(0, 5) == 0) random_add();
        else random_access();
      end
      drain();
    end

    $display("covered %0d results, %0d full-table add rejections, %0d regions at end",
             answers_seen, adds_rejected, map_count);
    if (mismatches == 0) $display("[address_region_map_top] OK");
    else $display("[address_region_map_top] ERROR");
    $finish;
  end
endmodule
